### design/esq_pkg.sv
// esq_pkg: shared types, codes and the date ordering key for the expiry sorted queue
// no dependencies; used by esq_cell and expiry_sorted_queue
package esq_pkg;

  localparam int CAPACITY_DEF = 16;
  localparam int FILL_W       = 5;
  localparam int KEY_W        = 23;

  localparam logic FUNC_INSERT = 1'b0;
  localparam logic FUNC_REMOVE = 1'b1;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  typedef struct packed {
    logic [15:0] id;
    logic [4:0]  day;
    logic [3:0]  month;
    logic [13:0] year;
  } entry_t;

  typedef struct packed {
    logic        func;
    logic [15:0] item_id;
    logic [4:0]  exp_day;
    logic [3:0]  exp_month;
    logic [13:0] exp_year;
  } req_t;

  typedef struct packed {
    status_t     status;
    logic [15:0] out_id;
    logic [4:0]  out_day;
    logic [3:0]  out_month;
    logic [13:0] out_year;
    logic [4:0]  fill_level;
  } rsp_t;

  // control broadcast to every cell in the chain
  typedef struct packed {
    logic   ins;
    logic   rem;
    entry_t item;
  } cell_ctl_t;

  // year, then month, then day
  function automatic logic [KEY_W-1:0] date_key(entry_t e);
    return {e.year, e.month, e.day};
  endfunction

endpackage

### design/expiry_sorted_queue.sv
// expiry_sorted_queue: bounded queue kept in ascending expiry order, built as a chain of cells
// depends on esq_pkg and esq_cell
//
// One word a cycle: busy is tied low, so a word is taken at every clock edge where start is
// high, and its result appears on rsp with done high in the next cycle. Every cell of the chain
// compares its own date against the incoming one in parallel and loads from itself, its left
// neighbor or the new word on an insert, or its right neighbor on a remove, so an insert or a
// remove completes in the cycle after it is taken. The receiver cannot stall; each result is
// shown for one cycle only. An insert into a full queue returns status full and leaves the
// queue alone; a remove on an empty queue returns status empty. Among equal dates the earlier
// arrival leaves first. fill_level is the count after the operation, in five bits.
module expiry_sorted_queue #(
  parameter int CAPACITY = esq_pkg::CAPACITY_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  output logic          busy,
  input  esq_pkg::req_t req,
  output logic          done,
  output esq_pkg::rsp_t rsp
);
  import esq_pkg::*;

  localparam int CNT_W = $clog2(CAPACITY + 1);

  logic [CNT_W-1:0]    count;
  logic [CNT_W-1:0]    count_next;
  logic [CAPACITY-1:0] vld;
  logic [CAPACITY-1:0] keep;
  entry_t              ent [CAPACITY];
  cell_ctl_t           ctl;
  logic                accept;
  logic                full;
  logic                empty;
  rsp_t                rsp_next;

  // never stalls the sender
  assign busy   = 1'b0;
  assign accept = start && !busy;
  assign full   = (count == CNT_W'(CAPACITY));
  assign empty  = (count == '0);

  // broadcast the operation; rejected operations leave the chain untouched
  always_comb begin
    ctl.ins        = accept && (req.func == FUNC_INSERT) && !full;
    ctl.rem        = accept && (req.func == FUNC_REMOVE) && !empty;
    ctl.item.id    = req.item_id;
    ctl.item.day   = req.exp_day;
    ctl.item.month = req.exp_month;
    ctl.item.year  = req.exp_year;
  end

  // occupied slots form a prefix of the chain, decoded from the count
  genvar i;
  generate
    for (i = 0; i < CAPACITY; i++) begin : g_cell
      entry_t prev_e;
      logic   prev_k;
      entry_t next_e;

      assign vld[i] = (count > CNT_W'(i));

      if (i == 0) begin : g_head
        // a virtual head before slot 0 always keeps its place
        assign prev_e = '0;
        assign prev_k = 1'b1;
      end else begin : g_body
        assign prev_e = ent[i-1];
        assign prev_k = keep[i-1];
      end

      if (i == CAPACITY - 1) begin : g_tail
        assign next_e = '0;
      end else begin : g_mid
        assign next_e = ent[i+1];
      end

      esq_cell u_cell (
        .clk        (clk),
        .ctl        (ctl),
        .valid      (vld[i]),
        .prev_entry (prev_e),
        .prev_keep  (prev_k),
        .next_entry (next_e),
        .entry      (ent[i]),
        .keep       (keep[i])
      );
    end
  endgenerate

  // count and result word
  always_comb begin
    count_next = count;
    rsp_next   = '0;
    if (ctl.ins) begin
      count_next = count + CNT_W'(1);
    end else if (ctl.rem) begin
      count_next         = count - CNT_W'(1);
      rsp_next.out_id    = ent[0].id;
      rsp_next.out_day   = ent[0].day;
      rsp_next.out_month = ent[0].month;
      rsp_next.out_year  = ent[0].year;
    end
    if (accept && (req.func == FUNC_INSERT) && full) begin
      rsp_next.status = ST_FULL;
    end else if (accept && (req.func == FUNC_REMOVE) && empty) begin
      rsp_next.status = ST_EMPTY;
    end else begin
      rsp_next.status = ST_DONE;
    end
    rsp_next.fill_level = FILL_W'(count_next);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      done  <= 1'b0;
    end else begin
      count <= count_next;
      done  <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      rsp <= rsp_next;
    end
  end

  // checks
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(CAPACITY))
    else $error("count beyond capacity");

  a_done_follows_start: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start))
    else $error("result without a taken word");

  a_full_level: assert property (@(posedge clk) disable iff (rst)
    (done && rsp.status == ST_FULL) |-> (rsp.fill_level == FILL_W'(CAPACITY)))
    else $error("full reject with queue not full");

  a_empty_level: assert property (@(posedge clk) disable iff (rst)
    (done && rsp.status == ST_EMPTY) |-> (rsp.fill_level == '0))
    else $error("empty status with entries held");

  a_front_sorted: assert property (@(posedge clk) disable iff (rst)
    (count > CNT_W'(1)) |-> (date_key(ent[0]) <= date_key(ent[1])))
    else $error("front entries out of order");

endmodule

### design/esq_cell.sv
// esq_cell: one slot of the sorted chain; holds one entry and trades with its neighbors
// depends on esq_pkg
module esq_cell (
  input  logic              clk,
  input  esq_pkg::cell_ctl_t ctl,
  input  logic              valid,
  input  esq_pkg::entry_t   prev_entry,
  input  logic              prev_keep,
  input  esq_pkg::entry_t   next_entry,
  output esq_pkg::entry_t   entry,
  output logic              keep
);
  import esq_pkg::*;

  entry_t entry_next;

  // stored entry stays put when it is not later than the new one
  assign keep = valid && (date_key(entry) <= date_key(ctl.item));

  always_comb begin
    entry_next = entry;
    if (ctl.ins) begin
      if (keep) begin
        entry_next = entry;
      end else if (prev_keep) begin
        entry_next = ctl.item;
      end else begin
        entry_next = prev_entry;
      end
    end else if (ctl.rem) begin
      entry_next = next_entry;
    end
  end

  always_ff @(posedge clk) begin
    entry <= entry_next;
  end

endmodule
